// File: rtl/core/bmpl_pkg.sv
`timescale 1ns / 1ps

package bmpl_pkg;

   typedef enum logic [3:0] {
      ST_INIT_SEED,
      ST_INIT_MUL,
      ST_INIT_RED,
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_DIGIT,
      ST_LOOK_B,
      ST_LOOK_C,
      ST_TERM_RED,
      ST_ACC_MUL,
      ST_ACC_RED,
      ST_FINISH
   } bmpl_state_type;

endpackage

// File: rtl/core/binomial_mod_prime_lucas_unit.sv
`timescale 1ns / 1ps

// C(n, k) mod PRIME by Lucas's theorem, one transaction at a time. After reset the block fills
// its factorial and inverse-factorial tables (two PRIME-deep memories) with req_ready low; the
// inverse sweep starts from (PRIME-1)! = PRIME-1 and walks down. A transaction processes one
// base-PRIME digit level of n and k after another, and finishes early when k exceeds n or a
// k digit exceeds its n digit. The work is done by one shared two-lane radix-16 remainder
// unit, which splits n and k into digits (VAL_PAD/4 steps per digit) and reduces every modular
// product (PROD_PAD/4 steps), and by the single read port of each table. A finished result
// waits in an output register, so the next transaction is accepted while the previous result
// is still pending.

module binomial_mod_prime_lucas_unit
   import bmpl_pkg::*;
#(
   parameter int PRIME       = 1009,
   parameter int VALUE_WIDTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [VALUE_WIDTH-1:0]     req_top_value,
   input  logic [VALUE_WIDTH-1:0]     req_choose_count,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [$clog2(PRIME)-1:0]   rsp_binomial_residue
);

   localparam int RES_W      = $clog2(PRIME);
   localparam int X_W        = RES_W + 4;
   localparam int PROD_W     = 2 * RES_W;
   localparam int VAL_PAD    = ((VALUE_WIDTH + 3) / 4) * 4;
   localparam int PROD_PAD   = ((PROD_W + 3) / 4) * 4;
   localparam int LANE_W     = (VAL_PAD > PROD_PAD) ? VAL_PAD : PROD_PAD;
   localparam int VAL_STEPS  = VAL_PAD / 4;
   localparam int PROD_STEPS = PROD_PAD / 4;
   localparam int CNT_W      = $clog2(LANE_W / 4 + 1);
   localparam int VAL_SHIFT  = LANE_W - VAL_PAD;
   localparam int PROD_SHIFT = LANE_W - PROD_PAD;

   localparam logic [RES_W-1:0] P_M1    = RES_W'(PRIME - 1);
   localparam logic [RES_W-1:0] P_TRUNC = RES_W'(PRIME);
   localparam logic [RES_W-1:0] ONE     = RES_W'(1);
   localparam logic [CNT_W-1:0] VAL_CNT  = CNT_W'(VAL_STEPS);
   localparam logic [CNT_W-1:0] PROD_CNT = CNT_W'(PROD_STEPS);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   bmpl_state_type state_ff, state_in;

   logic [1:0][LANE_W-1:0]  lane_ff, lane_in;
   logic [1:0][RES_W-1:0]   rem_ff, rem_in;
   logic [1:0][LANE_W-1:0]  step_lane;
   logic [1:0][RES_W-1:0]   step_rem;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0]  n_ff, n_in;
   logic [VALUE_WIDTH-1:0]  k_ff, k_in;
   logic [RES_W-1:0]        acc_ff, acc_in;
   logic [RES_W-1:0]        aux_ff, aux_in;
   logic [RES_W-1:0]        idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]        rsp_data_ff, rsp_data_in;

   logic [1:0][RES_W-1:0]   mul_a, mul_b;
   logic [1:0][PROD_W-1:0]  prod;

   logic [RES_W-1:0] fact_mem [PRIME];
   logic [RES_W-1:0] inv_mem  [PRIME];
   logic [RES_W-1:0] fact_rd_ff, inv_rd_ff;
   logic [RES_W-1:0] fact_raddr, inv_raddr, fact_waddr, inv_waddr;
   logic [RES_W-1:0] fact_wdata, inv_wdata;
   logic             fact_we, inv_we, fact_re, inv_re;

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_binomial_residue = rsp_data_ff;

   // radix-16 remainder step by PRIME, one per lane
   always_comb begin
      logic [X_W-1:0] x;
      logic [X_W-1:0] rx;
      logic [3:0]     qd;
      for (int l = 0; l < 2; l++) begin
         x  = {rem_ff[l], lane_ff[l][LANE_W-1 -: 4]};
         rx = x;
         qd = 4'd0;
         for (int d = 1; d < 16; d++) begin
            if (x >= X_W'(d * PRIME)) begin
               qd = 4'(d);
               rx = x - X_W'(d * PRIME);
            end
         end
         step_rem[l]  = rx[RES_W-1:0];
         step_lane[l] = {lane_ff[l][LANE_W-5:0], qd};
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         prod[l] = PROD_W'(mul_a[l]) * PROD_W'(mul_b[l]);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT_SEED: state_in = ST_INIT_MUL;
         ST_INIT_MUL:  state_in = ST_INIT_RED;
         ST_INIT_RED: begin
            if (cnt_ff == CNT_ONE) begin
               state_in = (idx_ff == P_M1) ? ST_IDLE : ST_INIT_MUL;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (k_ff > n_ff || n_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_ONE) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: state_in = (rem_ff[1] > rem_ff[0]) ? ST_FINISH : ST_LOOK_B;
         ST_LOOK_B: state_in = ST_LOOK_C;
         ST_LOOK_C: state_in = ST_TERM_RED;
         ST_TERM_RED: begin
            if (cnt_ff == CNT_ONE) begin
               state_in = ST_ACC_MUL;
            end
         end
         ST_ACC_MUL: state_in = ST_ACC_RED;
         ST_ACC_RED: begin
            if (cnt_ff == CNT_ONE) begin
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT_SEED;
      endcase
   end

   always_comb begin
      lane_in      = lane_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      aux_in       = aux_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mul_a[0]     = acc_ff;
      mul_b[0]     = fact_rd_ff;
      mul_a[1]     = aux_ff;
      mul_b[1]     = inv_rd_ff;
      fact_we      = 1'b0;
      inv_we       = 1'b0;
      fact_re      = 1'b0;
      inv_re       = 1'b0;
      fact_waddr   = '0;
      inv_waddr    = '0;
      fact_wdata   = '0;
      inv_wdata    = '0;
      fact_raddr   = '0;
      inv_raddr    = '0;

      case (state_ff)
         ST_INIT_SEED: begin
            fact_we    = 1'b1;
            fact_waddr = '0;
            fact_wdata = ONE;
            inv_we     = 1'b1;
            inv_waddr  = P_M1;
            inv_wdata  = P_M1;
            acc_in     = ONE;
            aux_in     = P_M1;
            idx_in     = ONE;
         end
         ST_INIT_MUL: begin
            mul_a[0] = acc_ff;
            mul_b[0] = idx_ff;
            mul_a[1] = aux_ff;
            mul_b[1] = P_TRUNC - idx_ff;
            for (int l = 0; l < 2; l++) begin
               lane_in[l] = LANE_W'(prod[l]) << PROD_SHIFT;
               rem_in[l]  = '0;
            end
            cnt_in = PROD_CNT;
         end
         ST_INIT_RED: begin
            lane_in = step_lane;
            rem_in  = step_rem;
            cnt_in  = cnt_ff - CNT_ONE;
            if (cnt_ff == CNT_ONE) begin
               fact_we    = 1'b1;
               fact_waddr = idx_ff;
               fact_wdata = step_rem[0];
               inv_we     = 1'b1;
               inv_waddr  = P_M1 - idx_ff;
               inv_wdata  = step_rem[1];
               acc_in     = step_rem[0];
               aux_in     = step_rem[1];
               idx_in     = idx_ff + ONE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               n_in   = req_top_value;
               k_in   = req_choose_count;
               acc_in = ONE;
            end
         end
         ST_CHECK: begin
            if (k_ff > n_ff) begin
               acc_in = '0;
            end else if (n_ff != '0) begin
               lane_in[0] = LANE_W'(n_ff) << VAL_SHIFT;
               lane_in[1] = LANE_W'(k_ff) << VAL_SHIFT;
               rem_in     = '0;
               cnt_in     = VAL_CNT;
            end
         end
         ST_DIV, ST_TERM_RED: begin
            lane_in = step_lane;
            rem_in  = step_rem;
            cnt_in  = cnt_ff - CNT_ONE;
         end
         ST_DIGIT: begin
            n_in = lane_ff[0][VALUE_WIDTH-1:0];
            k_in = lane_ff[1][VALUE_WIDTH-1:0];
            if (rem_ff[1] > rem_ff[0]) begin
               acc_in = '0;
            end else begin
               fact_re    = 1'b1;
               fact_raddr = rem_ff[0];
               inv_re     = 1'b1;
               inv_raddr  = rem_ff[1];
            end
         end
         ST_LOOK_B: begin
            aux_in    = inv_rd_ff;
            inv_re    = 1'b1;
            inv_raddr = rem_ff[0] - rem_ff[1];
         end
         ST_LOOK_C: begin
            for (int l = 0; l < 2; l++) begin
               lane_in[l] = LANE_W'(prod[l]) << PROD_SHIFT;
               rem_in[l]  = '0;
            end
            cnt_in = PROD_CNT;
         end
         ST_ACC_MUL: begin
            mul_a[0] = rem_ff[0];
            mul_b[0] = rem_ff[1];
            for (int l = 0; l < 2; l++) begin
               lane_in[l] = LANE_W'(prod[l]) << PROD_SHIFT;
               rem_in[l]  = '0;
            end
            cnt_in = PROD_CNT;
         end
         ST_ACC_RED: begin
            lane_in = step_lane;
            rem_in  = step_rem;
            cnt_in  = cnt_ff - CNT_ONE;
            if (cnt_ff == CNT_ONE) begin
               acc_in = step_rem[0];
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff & ~rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff     <= lane_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      aux_ff      <= aux_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (fact_we) begin
         fact_mem[fact_waddr] <= fact_wdata;
      end
      if (fact_re) begin
         fact_rd_ff <= fact_mem[fact_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (inv_we) begin
         inv_mem[inv_waddr] <= inv_wdata;
      end
      if (inv_re) begin
         inv_rd_ff <= inv_mem[inv_raddr];
      end
   end

endmodule
